[src/address_occurrence_counter_unit_assert.svh]
// assertion macros for the address occurrence counter unit
// used by address_occurrence_counter_unit.sv; needs nothing else
`ifndef ADDRESS_OCCURRENCE_COUNTER_UNIT_ASSERT_SVH
`define ADDRESS_OCCURRENCE_COUNTER_UNIT_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define AOC_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define AOC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/aoc_pkg.sv]
// shared types and constants of the address occurrence counter unit
// no dependencies
`default_nettype none

package aoc_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;
    localparam int ADDR_W            = 32;
    localparam int CNT_W             = 32;
    localparam int STATUS_W          = 3;
    localparam int READ_IDX_W        = 6;
    localparam int ENTRY_IDX_W       = 6;
    localparam int USED_OUT_W        = 7;

    // operation codes
    localparam logic OP_RECORD = 1'b0;
    localparam logic OP_READ   = 1'b1;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_HIT         = 3'd0,
        STAT_NEW         = 3'd1,
        STAT_FULL        = 3'd2,
        STAT_READ_OK     = 3'd3,
        STAT_READ_BEYOND = 3'd4
    } t_status;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_UPD
    } t_state;

    // commands from controller to datapath
    typedef struct packed {
        logic accept;
        logic look;
        logic finish;
    } t_ctl_cmd;

endpackage

`default_nettype wire

[src/address_occurrence_counter_unit.sv]
// Address occurrence counter: a histogram table of basic-block start addresses.
// Input channel (i_in_valid / o_in_stall) carries i_op, i_block_address and
// i_read_index; op record counts an address (hit or new entry; when the table
// is full every record is dropped), op read returns one stored entry. Output
// channel (o_out_valid / i_out_stall) gives one result per transaction: status,
// entry index, address, count after update and the number of entries in use.
// A transaction is captured on acceptance, then passes through the lookup state
// (cam match encode plus registered read of the count memory) and the update
// state that writes the new count back and loads the result register; a new
// transaction can be accepted in the update state of the previous one.
// A result waiting on a stalled receiver holds its payload; the next
// transaction is still accepted and runs up to its update cycle, where it waits
// until the output register frees up, stalling the input meanwhile.
// Reset (synchronous, active low) empties the table at once by clearing the
// used count; stale entries are never compared or read, so no clearing pass.
// depends on aoc_pkg, aoc_ctrl, aoc_datapath and the assertion macro header
`default_nettype none

module address_occurrence_counter_unit
    import aoc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic                    i_op,
    input  wire logic [ADDR_W-1:0]       i_block_address,
    input  wire logic [READ_IDX_W-1:0]   i_read_index,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output logic [STATUS_W-1:0]          o_status,
    output logic [ENTRY_IDX_W-1:0]       o_entry_index,
    output logic [ADDR_W-1:0]            o_entry_address,
    output logic [CNT_W-1:0]             o_entry_count,
    output logic [USED_OUT_W-1:0]        o_entries_used
);

`include "address_occurrence_counter_unit_assert.svh"

    t_ctl_cmd cmd;

    // controller
    aoc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd)
    );

    // datapath
    aoc_datapath #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_op            (i_op),
        .i_block_address (i_block_address),
        .i_read_index    (i_read_index),
        .o_status        (o_status),
        .o_entry_index   (o_entry_index),
        .o_entry_address (o_entry_address),
        .o_entry_count   (o_entry_count),
        .o_entries_used  (o_entries_used)
    );

    // sequencing and result checks
    `AOC_ASSERT_NEXT(a_accept_then_look, i_clk, i_rst_n, cmd.accept, cmd.look, "accept not followed by lookup")
    `AOC_ASSERT_SAME(a_no_accept_in_look, i_clk, i_rst_n, cmd.look, o_in_stall, "transaction accepted during lookup")
    `AOC_ASSERT_NEXT(a_finish_shows_result, i_clk, i_rst_n, cmd.finish, o_out_valid, "finished transaction without result")
    `AOC_ASSERT_SAME(a_hit_count_nonzero, i_clk, i_rst_n, o_out_valid && (o_status == STAT_HIT), o_entry_count != '0, "hit reported with zero count")

endmodule

`default_nettype wire

[src/aoc_ctrl.sv]
// controller state machine of the address occurrence counter unit
// depends on aoc_pkg
`default_nettype none

module aoc_ctrl
    import aoc_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  wire logic     i_out_stall,
    output t_ctl_cmd      o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   finish;
    logic   accept;
    logic   stall;

    // command and handshake outputs
    always_comb begin
        finish = (r_state == ST_UPD) && !(r_out_valid && i_out_stall);
        stall  = (r_state == ST_LOOK) || ((r_state == ST_UPD) && !finish);
        accept = i_in_valid && !stall;
        o_cmd.accept = accept;
        o_cmd.look   = (r_state == ST_LOOK);
        o_cmd.finish = finish;
        n_out_valid  = finish || (r_out_valid && i_out_stall);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                n_state = ST_UPD;
            end
            ST_UPD: begin
                if (finish) begin
                    n_state = accept ? ST_LOOK : ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // state and output valid registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = stall;
    assign o_out_valid = r_out_valid;

endmodule

`default_nettype wire

[src/aoc_datapath.sv]
// datapath of the address occurrence counter unit: address cam, entry memories,
// count update and result register; depends on aoc_pkg
`default_nettype none

module aoc_datapath
    import aoc_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire t_ctl_cmd                i_cmd,
    input  wire logic                    i_op,
    input  wire logic [ADDR_W-1:0]       i_block_address,
    input  wire logic [READ_IDX_W-1:0]   i_read_index,
    output logic [STATUS_W-1:0]          o_status,
    output logic [ENTRY_IDX_W-1:0]       o_entry_index,
    output logic [ADDR_W-1:0]            o_entry_address,
    output logic [CNT_W-1:0]             o_entry_count,
    output logic [USED_OUT_W-1:0]        o_entries_used
);

    localparam int IdxW  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int UsedW = $clog2(TABLE_ENTRIES + 1);
    localparam int RdW   = (UsedW > READ_IDX_W) ? UsedW : READ_IDX_W;

    // captured transaction
    logic                  r_op;
    logic [ADDR_W-1:0]     r_addr;
    logic [READ_IDX_W-1:0] r_ridx;
    logic [TABLE_ENTRIES-1:0] r_match;
    logic [TABLE_ENTRIES-1:0] n_match;

    // table state
    logic [UsedW-1:0]  r_used;
    logic [ADDR_W-1:0] r_cam [TABLE_ENTRIES];
    logic [ADDR_W-1:0] r_addr_mem [TABLE_ENTRIES];
    logic [CNT_W-1:0]  r_cnt_mem [TABLE_ENTRIES];
    logic [ADDR_W-1:0] r_rd_addr;
    logic [CNT_W-1:0]  r_rd_cnt;

    // lookup results
    t_status    r_status;
    t_status    n_status;
    logic [IdxW-1:0] r_idx;
    logic [IdxW-1:0] n_idx;
    logic [IdxW-1:0] hit_idx;
    logic       hit;
    logic       full;
    logic       rd_in_range;

    // update results
    logic [CNT_W-1:0]  upd_cnt;
    logic [ADDR_W-1:0] upd_addr;
    logic [ENTRY_IDX_W-1:0] upd_index;
    logic              cnt_wr;

    // result register
    t_status                r_o_status;
    logic [ENTRY_IDX_W-1:0] r_o_index;
    logic [ADDR_W-1:0]      r_o_addr;
    logic [CNT_W-1:0]       r_o_count;
    logic [USED_OUT_W-1:0]  r_o_used;

    // parallel compare of the incoming address against the used entries
    always_comb begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            n_match[i] = (UsedW'(i) < r_used) && (r_cam[i] == i_block_address);
        end
    end

    // capture on accept
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= i_op;
            r_addr  <= i_block_address;
            r_ridx  <= i_read_index;
            r_match <= n_match;
        end
    end

    // encode the one-hot match; stored addresses are distinct
    always_comb begin
        hit_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (r_match[i]) begin
                hit_idx = hit_idx | IdxW'(i);
            end
        end
        hit = |r_match;
    end

    // classify the transaction and pick the entry
    always_comb begin
        full        = (r_used == UsedW'(TABLE_ENTRIES));
        rd_in_range = (RdW'(r_ridx) < RdW'(r_used));
        n_idx       = IdxW'(r_used);
        if (r_op == OP_READ) begin
            n_status = rd_in_range ? STAT_READ_OK : STAT_READ_BEYOND;
            n_idx    = IdxW'(r_ridx);
        end else if (full) begin
            n_status = STAT_FULL;
        end else if (hit) begin
            n_status = STAT_HIT;
            n_idx    = hit_idx;
        end else begin
            n_status = STAT_NEW;
        end
    end

    // used count, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_cmd.look && (n_status == STAT_NEW)) begin
            r_used <= r_used + UsedW'(1);
        end
    end

    // lookup registers, cam append and address memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_status  <= n_status;
            r_idx     <= n_idx;
            r_rd_addr <= r_addr_mem[n_idx];
            if (n_status == STAT_NEW) begin
                r_cam[n_idx]      <= r_addr;
                r_addr_mem[n_idx] <= r_addr;
            end
        end
    end

    // count memory: read on lookup, write back on finish
    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_rd_cnt <= r_cnt_mem[n_idx];
        end
        if (cnt_wr) begin
            r_cnt_mem[r_idx] <= upd_cnt;
        end
    end

    // saturating count update and result fields
    always_comb begin
        cnt_wr    = 1'b0;
        upd_cnt   = '0;
        upd_addr  = '0;
        upd_index = '0;
        case (r_status)
            STAT_HIT: begin
                upd_cnt   = (r_rd_cnt == '1) ? r_rd_cnt : r_rd_cnt + CNT_W'(1);
                upd_addr  = r_addr;
                upd_index = ENTRY_IDX_W'(r_idx);
                cnt_wr    = i_cmd.finish;
            end
            STAT_NEW: begin
                upd_cnt   = CNT_W'(1);
                upd_addr  = r_addr;
                upd_index = ENTRY_IDX_W'(r_idx);
                cnt_wr    = i_cmd.finish;
            end
            STAT_READ_OK: begin
                upd_cnt   = r_rd_cnt;
                upd_addr  = r_rd_addr;
                upd_index = ENTRY_IDX_W'(r_ridx);
            end
            STAT_READ_BEYOND: begin
                upd_index = ENTRY_IDX_W'(r_ridx);
            end
            default: begin
                upd_index = '0;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_o_status <= r_status;
            r_o_index  <= upd_index;
            r_o_addr   <= upd_addr;
            r_o_count  <= upd_cnt;
            r_o_used   <= USED_OUT_W'(r_used);
        end
    end

    assign o_status        = r_o_status;
    assign o_entry_index   = r_o_index;
    assign o_entry_address = r_o_addr;
    assign o_entry_count   = r_o_count;
    assign o_entries_used  = r_o_used;

endmodule

`default_nettype wire
